// File: hdl/oel_pkg.sv
// shared types and constants for the ordered entry list
// no dependencies; imported by every module of the block
package oel_pkg;

  localparam int CAPACITY = 16;
  localparam int TAG_BITS = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int MODE_W   = 4;
  localparam int DAY_W    = 5;
  localparam int TAG_W    = 64;
  localparam int POS_W    = 5;
  localparam int COUNT_W  = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_INS_HEAD   = 4'd0,
    MODE_INS_SORTED = 4'd1,
    MODE_INS_TAIL   = 4'd2,
    MODE_RM_HEAD    = 4'd3,
    MODE_RM_TAIL    = 4'd4,
    MODE_RM_DAY     = 4'd5,
    MODE_FIND_DAY   = 4'd6,
    MODE_FIND_POS   = 4'd7,
    MODE_STATUS     = 4'd8
  } mode_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_LOAD,
    OP_LEFT,
    OP_RIGHT
  } cell_op_e;

  typedef struct packed {
    logic eq;
    logic lt;
    logic gt;
  } cell_flags_t;

  typedef struct packed {
    logic             ok;
    logic [CNT_W-1:0] count;
  } ctrl_res_t;

  typedef logic [CAPACITY-1:0] cell_vec_t;

  // isolate the lowest set bit
  function automatic cell_vec_t lowest_one(input cell_vec_t v);
    return v & (~v + cell_vec_t'(1));
  endfunction

  // bits at and above the set bit of a one-hot input
  function automatic cell_vec_t at_or_above(input cell_vec_t oh);
    return ~(oh - cell_vec_t'(1));
  endfunction

endpackage

// File: hdl/ordered_entry_list_top.sv
// ordered entry list: an accepted request's result is valid in the next cycle
// throughput one request per cycle while not stalled; the cell chain updates
// in the accept cycle and the result waits in an output register, so input
// stalls only while a finished result is held and the output side stalls
// reset clears the entry count and the output valid; cell contents are not reset
// depends on oel_pkg, oel_cell, oel_ctrl
module ordered_entry_list_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [oel_pkg::MODE_W-1:0]  mode_i,
  input  logic [oel_pkg::DAY_W-1:0]   day_i,
  input  logic [oel_pkg::TAG_W-1:0]   tag_i,
  input  logic [oel_pkg::POS_W-1:0]   position_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        ok_o,
  output logic [oel_pkg::DAY_W-1:0]   found_day_o,
  output logic [oel_pkg::TAG_W-1:0]   found_tag_o,
  output logic [oel_pkg::COUNT_W-1:0] entry_count_o,
  output logic                        is_empty_o,
  output logic                        is_full_o
);
  import oel_pkg::*;

  // handshake: the output register frees up when empty or being taken
  logic accept;
  assign in_stall_o = out_valid_o & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // cell chain wiring
  logic [DAY_W-1:0]    cell_day   [CAPACITY];
  logic [TAG_BITS-1:0] cell_tag   [CAPACITY];
  cell_flags_t         cell_flags [CAPACITY];
  cell_op_e            cell_ops   [CAPACITY];
  cell_vec_t           sel;
  ctrl_res_t           res;
  logic [TAG_BITS-1:0] new_tag;

  // the full tag is stored: TAG_BITS equals TAG_W
  assign new_tag = tag_i[TAG_BITS-1:0];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DAY_W-1:0]    left_day, right_day;
    logic [TAG_BITS-1:0] left_tag, right_tag;

    // head cell never shifts in from the left; tail cell reloads itself
    if (g == 0) begin : g_head
      assign left_day = day_i;
      assign left_tag = new_tag;
    end else begin : g_mid
      assign left_day = cell_day[g-1];
      assign left_tag = cell_tag[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_day = cell_day[g];
      assign right_tag = cell_tag[g];
    end else begin : g_body
      assign right_day = cell_day[g+1];
      assign right_tag = cell_tag[g+1];
    end

    oel_cell u_cell (
      .clk_i       (clk_i),
      .op_i        (cell_ops[g]),
      .key_i       (day_i),
      .new_tag_i   (new_tag),
      .left_day_i  (left_day),
      .left_tag_i  (left_tag),
      .right_day_i (right_day),
      .right_tag_i (right_tag),
      .day_o       (cell_day[g]),
      .tag_o       (cell_tag[g]),
      .flags_o     (cell_flags[g])
    );
  end

  oel_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .mode_i     (mode_i),
    .position_i (position_i),
    .flags_i    (cell_flags),
    .ops_o      (cell_ops),
    .sel_o      (sel),
    .res_o      (res)
  );

  // read out the hit cell: sel is one-hot or zero, zero leaves the fields at 0
  logic [DAY_W-1:0]    hit_day;
  logic [TAG_BITS-1:0] hit_tag;

  always_comb begin
    hit_day = '0;
    hit_tag = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_day = hit_day | (sel[i] ? cell_day[i] : '0);
      hit_tag = hit_tag | (sel[i] ? cell_tag[i] : '0);
    end
  end

  // output register
  logic                 out_valid_q;
  logic                 ok_q;
  logic [DAY_W-1:0]     found_day_q;
  logic [TAG_BITS-1:0]  found_tag_q;
  logic [CNT_W-1:0]     count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ok_q        <= res.ok;
      found_day_q <= hit_day;
      found_tag_q <= hit_tag;
      count_q     <= res.count;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ok_o          = ok_q;
  assign found_day_o   = found_day_q;
  assign found_tag_o   = TAG_W'(found_tag_q);
  // count fits the field as it stands: COUNT_W equals CNT_W
  assign entry_count_o = COUNT_W'(count_q);
  assign is_empty_o    = (count_q == '0);
  assign is_full_o     = (count_q == CNT_W'(CAPACITY));

`ifndef SYNTH
  // a failed request never carries entry data
  a_fail_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> found_day_o == '0 && found_tag_o == '0)
    else $error("failed result carries entry data");

  // stall toward the source only while a result is held
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result held");

  // every accepted request shows a result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted request produced no result");

  // count never goes past the cell count
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> count_q <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");
`endif

endmodule

// File: hdl/oel_cell.sv
// one storage cell of the entry chain: holds a day and a tag
// depends on oel_pkg
module oel_cell (
  input  logic                        clk_i,
  input  oel_pkg::cell_op_e           op_i,
  input  logic [oel_pkg::DAY_W-1:0]   key_i,
  input  logic [oel_pkg::TAG_BITS-1:0] new_tag_i,
  input  logic [oel_pkg::DAY_W-1:0]   left_day_i,
  input  logic [oel_pkg::TAG_BITS-1:0] left_tag_i,
  input  logic [oel_pkg::DAY_W-1:0]   right_day_i,
  input  logic [oel_pkg::TAG_BITS-1:0] right_tag_i,
  output logic [oel_pkg::DAY_W-1:0]   day_o,
  output logic [oel_pkg::TAG_BITS-1:0] tag_o,
  output oel_pkg::cell_flags_t        flags_o
);
  import oel_pkg::*;

  logic [DAY_W-1:0]    day_q, day_d;
  logic [TAG_BITS-1:0] tag_q, tag_d;

  always_comb begin
    day_d = day_q;
    tag_d = tag_q;
    case (op_i)
      OP_HOLD: begin
        day_d = day_q;
        tag_d = tag_q;
      end
      OP_LOAD: begin
        day_d = key_i;
        tag_d = new_tag_i;
      end
      OP_LEFT: begin
        day_d = left_day_i;
        tag_d = left_tag_i;
      end
      OP_RIGHT: begin
        day_d = right_day_i;
        tag_d = right_tag_i;
      end
      default: begin
        day_d = day_q;
        tag_d = tag_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    day_q <= day_d;
    tag_q <= tag_d;
  end

  assign day_o      = day_q;
  assign tag_o      = tag_q;
  assign flags_o.eq = (day_q == key_i);
  assign flags_o.lt = (day_q < key_i);
  assign flags_o.gt = (day_q > key_i);

endmodule

// File: hdl/oel_ctrl.sv
// list control: entry count, per-cell operations and hit select
// depends on oel_pkg
module oel_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [oel_pkg::MODE_W-1:0] mode_i,
  input  logic [oel_pkg::POS_W-1:0]  position_i,
  input  oel_pkg::cell_flags_t       flags_i [oel_pkg::CAPACITY],
  output oel_pkg::cell_op_e          ops_o [oel_pkg::CAPACITY],
  output oel_pkg::cell_vec_t         sel_o,
  output oel_pkg::ctrl_res_t         res_o
);
  import oel_pkg::*;

  logic [CNT_W-1:0] count_q, count_d;
  cell_vec_t        occ, cnt_oh, head_oh, tail_oh, match, cand, pos_oh;
  cell_vec_t        first_m, first_c, ins_oh, rm_oh, ins_ge, rm_ge;
  logic             full, is_ins, is_rm, ok;

  // per-cell decode; each cell uses its own flags, the tail bit also reads occ[i+1]
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      occ[i]    = CNT_W'(i) < count_q;
      cnt_oh[i] = CNT_W'(i) == count_q;
      match[i]  = occ[i] & flags_i[i].eq;
      pos_oh[i] = occ[i] & (int'(position_i) == i + 1);
      if (i == 0) begin
        cand[i] = occ[i] & flags_i[i].gt;
      end else begin
        cand[i] = occ[i] & ~flags_i[i].lt;
      end
      if (i == CAPACITY - 1) begin
        tail_oh[i] = occ[i];
      end else begin
        tail_oh[i] = occ[i] & ~occ[i+1];
      end
    end
    head_oh    = '0;
    head_oh[0] = occ[0];
  end

  assign first_m = lowest_one(match);
  assign first_c = lowest_one(cand);
  assign full    = (count_q == CNT_W'(CAPACITY));

  always_comb begin
    ins_oh = '0;
    rm_oh  = '0;
    sel_o  = '0;
    is_ins = 1'b0;
    is_rm  = 1'b0;
    ok     = 1'b0;
    case (mode_e'(mode_i))
      MODE_INS_HEAD: begin
        is_ins    = ~full;
        ins_oh[0] = 1'b1;
      end
      MODE_INS_SORTED: begin
        is_ins = ~full;
        ins_oh = (|cand) ? first_c : cnt_oh;
      end
      MODE_INS_TAIL: begin
        is_ins = ~full;
        ins_oh = cnt_oh;
      end
      MODE_RM_HEAD: begin
        rm_oh = head_oh;
        is_rm = |rm_oh;
      end
      MODE_RM_TAIL: begin
        rm_oh = tail_oh;
        is_rm = |rm_oh;
      end
      MODE_RM_DAY: begin
        rm_oh = first_m;
        is_rm = |rm_oh;
      end
      MODE_FIND_DAY: begin
        sel_o = first_m;
        ok    = |first_m;
      end
      MODE_FIND_POS: begin
        sel_o = pos_oh;
        ok    = |pos_oh;
      end
      MODE_STATUS: begin
        ok = 1'b1;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    if (is_rm) begin
      sel_o = rm_oh;
    end
    ok = ok | is_ins | is_rm;
  end

  assign ins_ge = at_or_above(ins_oh);
  assign rm_ge  = at_or_above(rm_oh);

  // insert: load at the slot, cells above take from the left
  // remove: cells from the slot up take from the right
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      ops_o[i] = OP_HOLD;
      if (accept_i && is_ins) begin
        if (ins_oh[i]) begin
          ops_o[i] = OP_LOAD;
        end else if (ins_ge[i]) begin
          ops_o[i] = OP_LEFT;
        end
      end else if (accept_i && is_rm && rm_ge[i]) begin
        ops_o[i] = OP_RIGHT;
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (is_ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (is_rm) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept_i) begin
      count_q <= count_d;
    end
  end

  assign res_o.ok    = ok;
  assign res_o.count = count_d;

endmodule
